>>> rtl/mbf_pkg.sv
// Shared types, constants and byte/CRC helpers for the Modbus RTU master framer.
package mbf_pkg;

    // Input item kinds (tuser on the slave side)
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_RX    = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    // Result kinds (tuser on the master side)
    localparam logic [1:0] OUT_TX     = 2'd0;
    localparam logic [1:0] OUT_DONE   = 2'd1;
    localparam logic [1:0] OUT_REFUSE = 2'd2;

    // Modbus function codes
    localparam logic [7:0] FUNC_WRITE_MULTI = 8'h10;
    localparam logic [7:0] FUNC_READ_HOLD   = 8'h03;

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Frame body lengths, CRC excluded
    localparam logic [3:0] BODY_LEN_WRITE = 4'd9;
    localparam logic [3:0] BODY_LEN_READ  = 4'd6;

    // Reply lengths in bytes
    localparam logic [3:0] REPLY_LEN_WRITE = 4'd8;
    localparam logic [3:0] REPLY_LEN_READ  = 4'd7;

    // Reply byte positions holding the register value
    localparam logic [3:0] REPLY_POS_HI = 4'd3;
    localparam logic [3:0] REPLY_POS_LO = 4'd4;

    localparam logic [15:0] IDLE_TICKS_RESET = 16'd11;
    localparam logic [15:0] QUIET_MAX        = 16'hFFFF;
    localparam int          QUEUE_DEPTH      = 2;

    // Command passed from the front end to the back end
    typedef enum logic [1:0] {
        CMD_FRAME,
        CMD_DONE,
        CMD_REFUSE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        is_write;
        logic [7:0]  node;
        logic [15:0] addr;
        logic [15:0] value;     // write data for a frame, read value for a reply
    } cmd_t;

    // One result item
    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [15:0] read_value;
        logic        reply_to_write;
    } res_t;

    // One byte of CRC-16, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Frame body byte at a given position
    function automatic logic [7:0] frame_byte(input cmd_t cmd, input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = cmd.node;
            4'd1:    b = cmd.is_write ? FUNC_WRITE_MULTI : FUNC_READ_HOLD;
            4'd2:    b = cmd.addr[15:8];
            4'd3:    b = cmd.addr[7:0];
            4'd4:    b = 8'h00;
            4'd5:    b = 8'h01;
            4'd6:    b = 8'h02;
            4'd7:    b = cmd.value[15:8];
            4'd8:    b = cmd.value[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/mbf_front.sv
// Front end: takes items, tracks line quiet time and reply progress, issues commands.
module mbf_front
    import mbf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_kind,
    input  logic [7:0]  in_node,
    input  logic [15:0] in_addr,
    input  logic [15:0] in_value,
    input  logic [7:0]  in_rx_data,
    // configuration
    input  logic        cfg_valid,
    input  logic [15:0] cfg_data,
    // command queue
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_REPLY
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        pend_write_reg, pend_write_next;
    logic [7:0]  pend_node_reg, pend_node_next;
    logic [15:0] pend_addr_reg, pend_addr_next;
    logic [15:0] pend_value_reg, pend_value_next;
    logic [15:0] quiet_reg, quiet_next;
    logic [3:0]  reply_cnt_reg, reply_cnt_next;
    logic [15:0] capt_reg, capt_next;
    logic [15:0] idle_ticks_reg, idle_ticks_next;

    logic        accept;
    logic [3:0]  reply_inc;
    logic [3:0]  reply_need;
    logic [15:0] quiet_inc;

    assign in_ready  = cmd_ready;
    assign accept    = in_valid && in_ready;
    assign reply_inc = reply_cnt_reg + 4'd1;
    assign reply_need = pend_write_reg ? REPLY_LEN_WRITE : REPLY_LEN_READ;
    assign quiet_inc = (quiet_reg != QUIET_MAX) ? quiet_reg + 16'd1 : quiet_reg;

    // next state and command issue
    always_comb
    begin
        phase_next      = phase_reg;
        pend_write_next = pend_write_reg;
        pend_node_next  = pend_node_reg;
        pend_addr_next  = pend_addr_reg;
        pend_value_next = pend_value_reg;
        quiet_next      = quiet_reg;
        reply_cnt_next  = reply_cnt_reg;
        capt_next       = capt_reg;
        idle_ticks_next = cfg_valid ? cfg_data : idle_ticks_reg;
        cmd_valid       = 1'b0;
        cmd.kind        = CMD_REFUSE;
        cmd.is_write    = pend_write_reg;
        cmd.node        = pend_node_reg;
        cmd.addr        = pend_addr_reg;
        cmd.value       = pend_value_reg;

        if (accept)
        begin
            unique case (in_kind)
                KIND_WRITE, KIND_READ:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        cmd_valid = 1'b1;
                        cmd.kind  = CMD_REFUSE;
                    end
                    else
                    begin
                        pend_write_next = (in_kind == KIND_WRITE);
                        pend_node_next  = in_node;
                        pend_addr_next  = in_addr;
                        pend_value_next = in_value;
                        if (quiet_reg >= idle_ticks_reg)
                        begin
                            // line already quiet: send at once
                            cmd_valid      = 1'b1;
                            cmd.kind       = CMD_FRAME;
                            cmd.is_write   = (in_kind == KIND_WRITE);
                            cmd.node       = in_node;
                            cmd.addr       = in_addr;
                            cmd.value      = in_value;
                            phase_next     = PH_REPLY;
                            reply_cnt_next = 4'd0;
                            capt_next      = 16'd0;
                        end
                        else
                        begin
                            phase_next = PH_WAIT;
                        end
                    end
                end
                KIND_RX:
                begin
                    if (phase_reg == PH_REPLY)
                    begin
                        if (reply_cnt_reg == REPLY_POS_HI)
                            capt_next = {in_rx_data, capt_reg[7:0]};
                        else if (reply_cnt_reg == REPLY_POS_LO)
                            capt_next = {capt_reg[15:8], in_rx_data};
                        if (reply_inc >= reply_need)
                        begin
                            cmd_valid      = 1'b1;
                            cmd.kind       = CMD_DONE;
                            cmd.value      = capt_next;
                            quiet_next     = 16'd0;
                            reply_cnt_next = 4'd0;
                            phase_next     = PH_IDLE;
                        end
                        else
                        begin
                            reply_cnt_next = reply_inc;
                        end
                    end
                end
                KIND_TICK:
                begin
                    quiet_next = quiet_inc;
                    if (phase_reg == PH_WAIT && quiet_inc >= idle_ticks_reg)
                    begin
                        cmd_valid      = 1'b1;
                        cmd.kind       = CMD_FRAME;
                        phase_next     = PH_REPLY;
                        reply_cnt_next = 4'd0;
                        capt_next      = 16'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            pend_write_reg <= 1'b0;
            pend_node_reg  <= 8'd0;
            pend_addr_reg  <= 16'd0;
            pend_value_reg <= 16'd0;
            quiet_reg      <= 16'd0;
            reply_cnt_reg  <= 4'd0;
            capt_reg       <= 16'd0;
            idle_ticks_reg <= IDLE_TICKS_RESET;
        end
        else
        begin
            phase_reg      <= phase_next;
            pend_write_reg <= pend_write_next;
            pend_node_reg  <= pend_node_next;
            pend_addr_reg  <= pend_addr_next;
            pend_value_reg <= pend_value_next;
            quiet_reg      <= quiet_next;
            reply_cnt_reg  <= reply_cnt_next;
            capt_reg       <= capt_next;
            idle_ticks_reg <= idle_ticks_next;
        end
    end

`ifndef SYNTH
    // reply counter never reaches the reply length while a reply is open
    a_reply_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_REPLY |-> reply_cnt_reg < reply_need)
        else $error("reply count overran reply length");

    // a completed reply always restarts the quiet count and returns to idle
    a_done_restarts_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd.kind == CMD_DONE |=>
            quiet_reg == 16'd0 && phase_reg == PH_IDLE)
        else $error("reply completion did not restart quiet count");
`endif

endmodule

>>> rtl/mbf_queue.sv
// Short command queue between front and back ends.
module mbf_queue
    import mbf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

>>> rtl/mbf_back.sv
// Back end: expands commands into frame bytes with CRC, replies and refusals.
module mbf_back
    import mbf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    // command queue
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    // result stream
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    typedef enum logic {
        BK_IDLE,
        BK_FRAME
    } bk_state_t;

    bk_state_t   state_reg, state_next;
    cmd_t        cur_reg, cur_next;
    logic [3:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic        out_valid_reg, out_valid_next;
    res_t        out_reg, out_next;

    logic        advance;
    logic        load_out;
    logic [3:0]  body_len;
    logic [7:0]  body_byte;

    assign advance   = !out_valid_reg || res_ready;
    assign cmd_ready = (state_reg == BK_IDLE) && advance;
    assign body_len  = cur_reg.is_write ? BODY_LEN_WRITE : BODY_LEN_READ;
    assign body_byte = frame_byte(cur_reg, idx_reg);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // command sequencing and byte generation
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        out_next   = out_reg;
        load_out   = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && advance)
                begin
                    unique case (cmd.kind)
                        CMD_FRAME:
                        begin
                            cur_next   = cmd;
                            idx_next   = 4'd0;
                            crc_next   = CRC_INIT;
                            state_next = BK_FRAME;
                        end
                        CMD_DONE:
                        begin
                            load_out                = 1'b1;
                            out_next.out_kind       = OUT_DONE;
                            out_next.tx_byte        = 8'd0;
                            out_next.last           = 1'b0;
                            out_next.read_value     = cmd.value;
                            out_next.reply_to_write = cmd.is_write;
                        end
                        CMD_REFUSE:
                        begin
                            load_out                = 1'b1;
                            out_next.out_kind       = OUT_REFUSE;
                            out_next.tx_byte        = 8'd0;
                            out_next.last           = 1'b0;
                            out_next.read_value     = 16'd0;
                            out_next.reply_to_write = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            BK_FRAME:
            begin
                if (advance)
                begin
                    load_out                = 1'b1;
                    out_next.out_kind       = OUT_TX;
                    out_next.last           = 1'b0;
                    out_next.read_value     = 16'd0;
                    out_next.reply_to_write = 1'b0;
                    idx_next                = idx_reg + 4'd1;
                    if (idx_reg < body_len)
                    begin
                        out_next.tx_byte = body_byte;
                        crc_next         = crc16_byte(crc_reg, body_byte);
                    end
                    else if (idx_reg == body_len)
                    begin
                        out_next.tx_byte = crc_reg[7:0];
                    end
                    else
                    begin
                        // CRC high byte closes the frame
                        out_next.tx_byte = crc_reg[15:8];
                        out_next.last    = 1'b1;
                        state_next       = BK_IDLE;
                    end
                end
            end
            default: ;
        endcase

        if (load_out)
            out_valid_next = 1'b1;
        else if (res_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cur_reg       <= '0;
            idx_reg       <= 4'd0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

`ifndef SYNTH
    // only transmit bytes may carry the frame end mark
    a_last_only_on_tx: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last |-> res.out_kind == OUT_TX)
        else $error("frame end mark on a non-transmit result");

    // byte index stays within body plus two CRC bytes
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_FRAME |-> idx_reg <= body_len + 4'd1)
        else $error("frame byte index out of range");

    // emitting the closing byte returns the sequencer to idle
    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && out_next.last |=> state_reg == BK_IDLE && res.last)
        else $error("frame end did not release the sequencer");
`endif

endmodule

>>> rtl/modbus_rtu_master_framer.sv
// Top level of the Modbus RTU master framer: stream ports, front end, queue, back end.
// Items (write request, read request, received byte, tick) are taken one per clock
// while the command queue has room; each item is handled in the cycle it is accepted.
// A request is held until idle_ticks ticks of quiet, then the back end sends the frame
// one byte per cycle while the receiver takes them, with its CRC-16 (low byte first),
// tlast on the final byte: a write frame has 11 bytes and a read frame 8. Reply
// completion and refusal each give a single result item. After 8 (write) or 7 (read)
// reply bytes the value from reply bytes 3 and 4 is reported; a request made while busy
// is refused. The reply CRC is not checked.
module modbus_rtu_master_framer
    import mbf_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // node[7:0], reg_addr[23:8], value[39:24], rx_data[47:40]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // tx_byte[7:0], read_value[23:8], reply_to_write[24], zero
    output logic [1:0]  m_tuser,   // out_kind[1:0]
    output logic        m_tlast,
    // idle_ticks register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic fq_valid, fq_ready;
    cmd_t fq_cmd;
    logic qb_valid, qb_ready;
    cmd_t qb_cmd;
    res_t res;

    assign cfg_ready = 1'b1;

    mbf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser),
        .in_node    (s_tdata[7:0]),
        .in_addr    (s_tdata[23:8]),
        .in_value   (s_tdata[39:24]),
        .in_rx_data (s_tdata[47:40]),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .cmd_valid  (fq_valid),
        .cmd_ready  (fq_ready),
        .cmd        (fq_cmd)
    );

    mbf_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    mbf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd       (qb_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // result packing
    assign m_tdata = {7'd0, res.reply_to_write, res.read_value, res.tx_byte};
    assign m_tuser = res.out_kind;
    assign m_tlast = res.last;

endmodule

>>> tb/modbus_rtu_master_framer_tb.sv
// Self-checking stream testbench for the Modbus RTU master framer.
module modbus_rtu_master_framer_tb;

    import mbf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transfer on any channel
    localparam int SETTLE_CYCLES  = 30;     // hold-off before a register write
    localparam int DRAIN_CYCLES   = 40;     // trailing wait after the last result

    // receiver stall patterns
    localparam logic [1:0] SINK_OPEN   = 2'd0;
    localparam logic [1:0] SINK_RANDOM = 2'd1;
    localparam logic [1:0] SINK_SPARSE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_REPLY
    } link_state_t;

    // one input item, unpacked from the stream fields
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  node;
        logic [15:0] addr;
        logic [15:0] val;
        logic [7:0]  rx;
    } in_item_t;

    // one row of the directed table
    typedef struct packed {
        in_item_t item;
        int       reps;
        bit       fixed;     // fixed_res replaces the prediction on the last repeat
        res_t     fixed_res;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // node[7:0], reg_addr[23:8], value[39:24], rx_data[47:40]
    logic [1:0]  s_tuser;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;   // tx_byte[7:0], read_value[23:8], reply_to_write[24], zero
    logic [1:0]  m_tuser;   // out_kind[1:0]
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // framer model state
    link_state_t mdl_phase;
    logic        mdl_is_write;
    logic [7:0]  mdl_node;
    logic [15:0] mdl_addr;
    logic [15:0] mdl_value;
    logic [15:0] mdl_quiet;
    logic [3:0]  mdl_rcount;
    logic [15:0] mdl_captured;
    logic [15:0] mdl_idle;

    res_t        step_results[$];   // results caused by the item just taken
    res_t        due_outputs[$];    // results still to arrive, oldest first
    stim_row_t   dir_tab[$];

    int          burst_left = 0;
    int          fault_count = 0;
    int          stall_cycles = 0;
    logic [1:0]  sink_mode = SINK_OPEN;
    int          sink_span = 0;
    int          sink_phase = 0;

    modbus_rtu_master_framer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock, period 12
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic res_t mk_res(input logic [1:0] ok, input logic [7:0] tx,
                                    input logic lst, input logic [15:0] rv,
                                    input logic rw);
        res_t r;
        r.out_kind       = ok;
        r.tx_byte        = tx;
        r.last           = lst;
        r.read_value     = rv;
        r.reply_to_write = rw;
        return r;
    endfunction

    function automatic in_item_t mk_item(input logic [1:0] k, input logic [7:0] nd,
                                         input logic [15:0] ad, input logic [15:0] vl,
                                         input logic [7:0] rb);
        in_item_t it;
        it.kind = k;
        it.node = nd;
        it.addr = ad;
        it.val  = vl;
        it.rx   = rb;
        return it;
    endfunction

    // random content in every field, kind as given
    function automatic in_item_t rand_item(input logic [1:0] k);
        return mk_item(k, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    endfunction

    function automatic stim_row_t mk_row(input in_item_t it, input int reps,
                                         input bit fixed, input res_t res);
        stim_row_t row;
        row.item      = it;
        row.reps      = reps;
        row.fixed     = fixed;
        row.fixed_res = res;
        return row;
    endfunction

    // CRC-16, reflected, one bit at a time
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int b = 0; b < 8; b++)
        begin
            fb = c[0] ^ d[b];
            c  = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // build the pending frame and queue its bytes
    task automatic emit_frame();
        logic [7:0]  fbytes [0:10];
        logic [15:0] crc;
        int          nbody;
        fbytes[0] = mdl_node;
        fbytes[1] = mdl_is_write ? FUNC_WRITE_MULTI : FUNC_READ_HOLD;
        fbytes[2] = mdl_addr[15:8];
        fbytes[3] = mdl_addr[7:0];
        fbytes[4] = 8'h00;
        fbytes[5] = 8'h01;
        fbytes[6] = 8'h02;
        fbytes[7] = mdl_value[15:8];
        fbytes[8] = mdl_value[7:0];
        nbody = mdl_is_write ? 9 : 6;
        crc = CRC_INIT;
        for (int i = 0; i < nbody; i++)
            crc = crc_update(crc, fbytes[i]);
        fbytes[nbody]     = crc[7:0];
        fbytes[nbody + 1] = crc[15:8];
        for (int i = 0; i < nbody + 2; i++)
            step_results.push_back(mk_res(OUT_TX, fbytes[i], i == nbody + 1, 16'h0, 1'b0));
        mdl_phase    = ST_REPLY;
        mdl_rcount   = 4'd0;
        mdl_captured = 16'h0;
    endtask

    // advance the model by one accepted item
    task automatic framer_step(input in_item_t it);
        logic [3:0] need;
        step_results.delete();
        case (it.kind)
            KIND_WRITE, KIND_READ:
            begin
                if (mdl_phase != ST_IDLE)
                    step_results.push_back(mk_res(OUT_REFUSE, 8'h0, 1'b0, 16'h0, 1'b0));
                else
                begin
                    mdl_is_write = (it.kind == KIND_WRITE);
                    mdl_node     = it.node;
                    mdl_addr     = it.addr;
                    mdl_value    = it.val;
                    mdl_phase    = ST_WAIT;
                    if (mdl_quiet >= mdl_idle)
                        emit_frame();
                end
            end
            KIND_RX:
            begin
                need = mdl_is_write ? REPLY_LEN_WRITE : REPLY_LEN_READ;
                if (mdl_phase == ST_REPLY)
                begin
                    if (mdl_rcount == REPLY_POS_HI)
                        mdl_captured[15:8] = it.rx;
                    else if (mdl_rcount == REPLY_POS_LO)
                        mdl_captured[7:0] = it.rx;
                    mdl_rcount = mdl_rcount + 4'd1;
                    if (mdl_rcount >= need)
                    begin
                        step_results.push_back(mk_res(OUT_DONE, 8'h0, 1'b0, mdl_captured,
                                                      mdl_is_write));
                        mdl_quiet  = 16'h0;
                        mdl_rcount = 4'd0;
                        mdl_phase  = ST_IDLE;
                    end
                end
            end
            KIND_TICK:
            begin
                if (mdl_quiet != QUIET_MAX)
                    mdl_quiet = mdl_quiet + 16'd1;
                if (mdl_phase == ST_WAIT && mdl_quiet >= mdl_idle)
                    emit_frame();
            end
        endcase
    endtask

    // offer one item in bursts with random gaps; predict once it is taken
    task automatic push_item(input in_item_t it, input bit fixed, input res_t fixed_res);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {it.rx, it.val, it.addr, it.node};
        do
            @(posedge clk);
        while (!s_tready);
        framer_step(it);
        if (fixed)
            due_outputs.push_back(fixed_res);
        else
            foreach (step_results[i])
                due_outputs.push_back(step_results[i]);
    endtask

    // finish any open exchange so the model ends idle, then release the bus
    task automatic close_out();
        while (mdl_phase == ST_WAIT)
            push_item(rand_item(KIND_TICK), 1'b0, '0);
        while (mdl_phase == ST_REPLY)
            push_item(rand_item(KIND_RX), 1'b0, '0);
        s_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    // register write, only once every result has come in
    task automatic write_idle_ticks(input logic [15:0] v);
        while (due_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mdl_idle = v;
    endtask

    // mostly full request/reply exchanges, with refusals, strays and loose items
    task automatic run_traffic(input int n_items);
        int done_items;
        done_items = 0;
        while (done_items < n_items)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                push_item(rand_item($urandom_range(0, 1) ? KIND_WRITE : KIND_READ),
                          1'b0, '0);
                done_items++;
                while (mdl_phase == ST_WAIT)
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        if ($urandom_range(0, 1))
                        begin
                            push_item(rand_item(2'($urandom_range(0, 1))), 1'b0, '0);
                            done_items++;
                        end
                        else
                            push_item(rand_item(KIND_RX), 1'b0, '0);
                    end
                    else
                    begin
                        push_item(rand_item(KIND_TICK), 1'b0, '0);
                        done_items++;
                    end
                end
                while (mdl_phase == ST_REPLY)
                begin
                    if ($urandom_range(0, 9) == 0)
                        push_item(rand_item(2'($urandom_range(0, 1)) | 2'($urandom_range(0, 1)
                                  ? KIND_TICK : KIND_WRITE)), 1'b0, '0);
                    else
                        push_item(rand_item(KIND_RX), 1'b0, '0);
                    done_items++;
                end
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: push_item(rand_item(KIND_TICK), 1'b0, '0);
                    1: push_item(rand_item(KIND_RX), 1'b0, '0);
                    default: push_item(rand_item(2'($urandom_range(0, 1))), 1'b0, '0);
                endcase
                done_items++;
            end
        end
        close_out();
    endtask

    // receiver: open, random and sparse stretches
    always @(posedge clk)
    begin
        if (sink_span == 0)
        begin
            sink_mode <= 2'($urandom_range(0, 2));
            sink_span <= $urandom_range(8, 60);
        end
        else
            sink_span <= sink_span - 1;
        sink_phase <= (sink_phase == 2) ? 0 : sink_phase + 1;
        case (sink_mode)
            SINK_OPEN:   m_tready <= 1'b1;
            SINK_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
            SINK_SPARSE: m_tready <= (sink_phase == 0);
            default:     m_tready <= 1'b1;
        endcase
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_outputs.size() == 0)
            begin
                $display("%0t: result with nothing pending: expected none, got kind %0d data %h",
                         $time, m_tuser, m_tdata);
                fault_count++;
            end
            else
            begin
                want = due_outputs.pop_front();
                if (m_tuser !== want.out_kind)
                begin
                    $display("%0t: out_kind mismatch: expected %0d, got %0d",
                             $time, want.out_kind, m_tuser);
                    fault_count++;
                end
                if (m_tdata[7:0] !== want.tx_byte)
                begin
                    $display("%0t: tx_byte mismatch: expected %h, got %h",
                             $time, want.tx_byte, m_tdata[7:0]);
                    fault_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last mismatch: expected %b, got %b",
                             $time, want.last, m_tlast);
                    fault_count++;
                end
                if (m_tdata[23:8] !== want.read_value)
                begin
                    $display("%0t: read_value mismatch: expected %h, got %h",
                             $time, want.read_value, m_tdata[23:8]);
                    fault_count++;
                end
                if (m_tdata[24] !== want.reply_to_write)
                begin
                    $display("%0t: reply_to_write mismatch: expected %b, got %b",
                             $time, want.reply_to_write, m_tdata[24]);
                    fault_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_TICK;
        cfg_valid = 1'b0;
        cfg_data  = '0;

        mdl_phase    = ST_IDLE;
        mdl_is_write = 1'b0;
        mdl_node     = 8'h0;
        mdl_addr     = 16'h0;
        mdl_value    = 16'h0;
        mdl_quiet    = 16'h0;
        mdl_rcount   = 4'd0;
        mdl_captured = 16'h0;
        mdl_idle     = IDLE_TICKS_RESET;

        // directed: reset quiet count of eleven ticks, refusals, both replies
        dir_tab.push_back(mk_row(mk_item(KIND_RX, 8'h00, 16'h0000, 16'h0000, 8'h55),
                                 1, 1'b0, '0));   // stray byte while idle
        dir_tab.push_back(mk_row(mk_item(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00),
                                 3, 1'b0, '0));
        dir_tab.push_back(mk_row(mk_item(KIND_READ, 8'h00, 16'h0000, 16'h0000, 8'h00),
                                 1, 1'b0, '0));   // held, line not quiet yet
        dir_tab.push_back(mk_row(mk_item(KIND_WRITE, 8'h12, 16'h3456, 16'h789A, 8'h00),
                                 1, 1'b1, mk_res(OUT_REFUSE, 8'h0, 1'b0, 16'h0, 1'b0)));
        dir_tab.push_back(mk_row(mk_item(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00),
                                 8, 1'b0, '0));   // frame goes on the eleventh tick
        dir_tab.push_back(mk_row(mk_item(KIND_READ, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF),
                                 1, 1'b1, mk_res(OUT_REFUSE, 8'h0, 1'b0, 16'h0, 1'b0)));
        dir_tab.push_back(mk_row(mk_item(KIND_RX, 8'h00, 16'h0000, 16'h0000, 8'h00),
                                 3, 1'b0, '0));
        dir_tab.push_back(mk_row(mk_item(KIND_RX, 8'h00, 16'h0000, 16'h0000, 8'hAB),
                                 1, 1'b0, '0));
        dir_tab.push_back(mk_row(mk_item(KIND_RX, 8'h00, 16'h0000, 16'h0000, 8'hCD),
                                 1, 1'b0, '0));
        dir_tab.push_back(mk_row(mk_item(KIND_RX, 8'h00, 16'h0000, 16'h0000, 8'h5A),
                                 1, 1'b0, '0));
        dir_tab.push_back(mk_row(mk_item(KIND_RX, 8'h00, 16'h0000, 16'h0000, 8'hA5),
                                 1, 1'b1, mk_res(OUT_DONE, 8'h0, 1'b0, 16'hABCD, 1'b0)));
        dir_tab.push_back(mk_row(mk_item(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00),
                                 11, 1'b0, '0));
        dir_tab.push_back(mk_row(mk_item(KIND_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF),
                                 1, 1'b0, '0));   // quiet already reached, sent at once
        dir_tab.push_back(mk_row(mk_item(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00),
                                 2, 1'b0, '0));
        dir_tab.push_back(mk_row(mk_item(KIND_RX, 8'h00, 16'h0000, 16'h0000, 8'hFF),
                                 4, 1'b0, '0));
        dir_tab.push_back(mk_row(mk_item(KIND_RX, 8'h00, 16'h0000, 16'h0000, 8'h00),
                                 1, 1'b0, '0));
        dir_tab.push_back(mk_row(mk_item(KIND_RX, 8'h00, 16'h0000, 16'h0000, 8'h3C),
                                 2, 1'b0, '0));
        dir_tab.push_back(mk_row(mk_item(KIND_RX, 8'h00, 16'h0000, 16'h0000, 8'hC3),
                                 1, 1'b1, mk_res(OUT_DONE, 8'h0, 1'b0, 16'hFF00, 1'b1)));
        dir_tab.push_back(mk_row(mk_item(KIND_RX, 8'h00, 16'h0000, 16'h0000, 8'h00),
                                 1, 1'b0, '0));   // stray byte after the reply
        dir_tab.push_back(mk_row(mk_item(KIND_WRITE, 8'h00, 16'h0000, 16'h0000, 8'h00),
                                 1, 1'b0, '0));
        dir_tab.push_back(mk_row(mk_item(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00),
                                 11, 1'b0, '0));
        dir_tab.push_back(mk_row(mk_item(KIND_RX, 8'h00, 16'h0000, 16'h0000, 8'h00),
                                 7, 1'b0, '0));
        dir_tab.push_back(mk_row(mk_item(KIND_RX, 8'h00, 16'h0000, 16'h0000, 8'h00),
                                 1, 1'b1, mk_res(OUT_DONE, 8'h0, 1'b0, 16'h0000, 1'b1)));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            for (int r = 0; r < dir_tab[i].reps; r++)
                push_item(dir_tab[i].item, dir_tab[i].fixed && (r == dir_tab[i].reps - 1),
                          dir_tab[i].fixed_res);
        close_out();

        // random traffic over several quiet settings
        write_idle_ticks(16'd0);
        run_traffic(30);
        write_idle_ticks(16'd1);
        run_traffic(25);
        write_idle_ticks(16'($urandom_range(2, 24)));
        run_traffic(40);

        write_idle_ticks(16'($urandom_range(0, 6)));
        run_traffic(30);

        while (due_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0 && due_outputs.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
